// ===== hw/rtl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary similarity engine package
// Shared widths, register and coefficient codes, and request structs for the
// iterative divide and square root units.
// ----------------------------------------------------------------------------
package bse_pkg;

    // Matrix dimension: cells with a row or column index of DIM or more are dropped
    localparam int DIM = 64;

    // Stream payload widths (whole bytes) and configuration field widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 88;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;

    // Datapath widths
    localparam int TALLY_W = 13;
    localparam int NUM_W = 40;
    localparam int MUL_W = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int FRAC_W = 16;
    localparam int ROOT_SHIFT = 2 * FRAC_W + 2;
    localparam int COEF_W = 32;

    // Restoring divider: dividend below 2^86, divisor below 2^56
    localparam int DIV_NW = 86;
    localparam int DIV_DW = 56;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Digit-by-digit square root
    localparam int SQ_W = 86;
    localparam int SQ_RW = SQ_W / 2;
    localparam int SQ_CW = $clog2(SQ_RW + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METRIC    = 3'd0,
        CFG_DIAG      = 3'd1,
        CFG_EXCL_EN   = 3'd2,
        CFG_EXCL_IDX  = 3'd3,
        CFG_NORM      = 3'd4,
        CFG_ROWS      = 3'd5
    } cfg_idx_t;

    // Coefficient selector codes
    typedef enum logic [4:0] {
        MET_JACCARD     = 5'd0,
        MET_DICE        = 5'd1,
        MET_JACCARD3W   = 5'd2,
        MET_FAITH       = 5'd3,
        MET_GOWER_LEG   = 5'd4,
        MET_RUSSELL_RAO = 5'd5,
        MET_PEARSON_HER = 5'd6,
        MET_HAMMING     = 5'd7,
        MET_DENNIS      = 5'd8,
        MET_TARWID      = 5'd9,
        MET_YULEQ       = 5'd10,
        MET_YULEW       = 5'd11,
        MET_YULEQ_DIST  = 5'd12,
        MET_MICHAEL     = 5'd13,
        MET_PEIRCE      = 5'd14,
        MET_GOODMAN_KR  = 5'd15,
        MET_ANDERBERG   = 5'd16,
        MET_HAMANN      = 5'd17,
        MET_MEAN_MANH   = 5'd18,
        MET_SIZED_DIFF  = 5'd19,
        MET_SHAPE_DIFF  = 5'd20,
        MET_DISPERSION  = 5'd21,
        MET_FSCORE      = 5'd22
    } metric_t;

    // Product slots filled by the shared multiplier, in schedule order
    typedef enum logic [3:0] {
        P_AD  = 4'd0,
        P_BC  = 4'd1,
        P_AB  = 4'd2,
        P_CD  = 4'd3,
        P_P1  = 4'd4,
        P_P2  = 4'd5,
        P_SAD = 4'd6,
        P_SBC = 4'd7,
        P_TT  = 4'd8,
        P_DBC = 4'd9,
        P_NA  = 4'd10,
        P_NBC = 4'd11,
        P_NP1 = 4'd12,
        P_RR  = 4'd13,
        P_MSQ = 4'd14
    } prod_t;

    localparam int PROD_N = 15;

    // Requests to the iterative units
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } sq_req_t;

endpackage

// ===== hw/rtl/binary_similarity_engine.sv =====
// ----------------------------------------------------------------------------
// Binary similarity engine
// Counts the 2x2 contingency of two binary matrices cell by cell and, on the
// last cell, computes the selected coefficient in signed Q15.16.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction carries
//  s_*       in         one matrix cell: row, column, both bits, tlast = last
//  m_*       out        coefficient and four tallies, tuser = undefined flag
//  cfg_*     in         one register write, no read-back
//
//  Cells without tlast are counted while s_tready stays high.
//  A last cell starts the sequencer: 14 multiplier steps, then a divide;
//  root coefficients square the numerator, then run the divide and a
//  root; Yule W takes two roots then a divide. s_tready is low until
//  the result is loaded into the output register.
//  One result waits in the output register while new cells are counted.
//  Reset (aresetn, synchronous) clears tallies, configuration, state and valid flags.
// ----------------------------------------------------------------------------
module binary_similarity_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [5:0] cell_row, [11:6] cell_col, [12] bit_first, [13] bit_second
    input  logic [bse_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] coefficient, [44:32] count_both, [57:45] count_first_only,
    // [70:58] count_second_only, [83:71] count_neither
    output logic [bse_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] undefined_flag
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import bse_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_MUL      = 13'b0000000000010,
        ST_COMPOSE  = 13'b0000000000100,
        ST_ROOTSQ   = 13'b0000000001000,
        ST_DIV_GO   = 13'b0000000010000,
        ST_DIV_WAIT = 13'b0000000100000,
        ST_SQX_GO   = 13'b0000001000000,
        ST_SQX_WAIT = 13'b0000010000000,
        ST_SQY_GO   = 13'b0000100000000,
        ST_SQY_WAIT = 13'b0001000000000,
        ST_SQW_GO   = 13'b0010000000000,
        ST_SQW_WAIT = 13'b0100000000000,
        ST_RESULT   = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        MODE_DIV   = 2'd0,
        MODE_ROOT  = 2'd1,
        MODE_YULEW = 2'd2,
        MODE_UNDEF = 2'd3
    } mode_t;

    localparam logic signed [NUM_W-1:0] NUM_ONE = NUM_W'(1);

    // Configuration
    logic [4:0]         metric_reg;
    logic               diag_reg;
    logic               excl_en_reg;
    logic [5:0]         excl_idx_reg;
    logic               norm_reg;
    logic [6:0]         rows_reg;

    // Tallies a, b, c, d
    logic [TALLY_W-1:0] ta_reg, tb_reg, tc_reg, td_reg;

    // Sequencer
    state_t             state_reg;
    prod_t              step_reg;
    mode_t              mode_reg;
    logic               undef_reg;
    logic [PROD_W-1:0]  prod_reg [PROD_N];
    logic signed [NUM_W-1:0] num_reg, den_reg;
    logic [DIV_DW-1:0]  root_reg;
    logic [SQ_RW-1:0]   xroot_reg;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    // Cell fields
    logic [5:0] cell_row, cell_col;
    logic       bit_first, bit_second, s_accept, skip;

    assign cell_row   = s_tdata[5:0];
    assign cell_col   = s_tdata[11:6];
    assign bit_first  = s_tdata[12];
    assign bit_second = s_tdata[13];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;

    assign skip = (32'(cell_row) >= DIM) || (32'(cell_col) >= DIM) ||
                  (!diag_reg && (cell_row == cell_col)) ||
                  (excl_en_reg && ((cell_row == excl_idx_reg) ||
                                   (cell_col == excl_idx_reg)));

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_reg   <= '0;
            diag_reg     <= 1'b0;
            excl_en_reg  <= 1'b0;
            excl_idx_reg <= '0;
            norm_reg     <= 1'b0;
            rows_reg     <= 7'd64;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_METRIC:   metric_reg   <= cfg_wdata[4:0];
                CFG_DIAG:     diag_reg     <= cfg_wdata[0];
                CFG_EXCL_EN:  excl_en_reg  <= cfg_wdata[0];
                CFG_EXCL_IDX: excl_idx_reg <= cfg_wdata[5:0];
                CFG_NORM:     norm_reg     <= cfg_wdata[0];
                CFG_ROWS:     rows_reg     <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Sums of tallies
    logic [TALLY_W:0]   s_ab, s_ac, s_bd, s_cd, s_apd, s_bpc;
    logic [TALLY_W-1:0] s_bmc;
    logic [TALLY_W+1:0] s_t;

    assign s_ab  = {1'b0, ta_reg} + {1'b0, tb_reg};
    assign s_ac  = {1'b0, ta_reg} + {1'b0, tc_reg};
    assign s_bd  = {1'b0, tb_reg} + {1'b0, td_reg};
    assign s_cd  = {1'b0, tc_reg} + {1'b0, td_reg};
    assign s_apd = {1'b0, ta_reg} + {1'b0, td_reg};
    assign s_bpc = {1'b0, tb_reg} + {1'b0, tc_reg};
    assign s_bmc = (tb_reg >= tc_reg) ? tb_reg - tc_reg : tc_reg - tb_reg;
    assign s_t   = {1'b0, s_ab} + {1'b0, s_cd};

    // Shared multiplier operand select
    prod_t              mul_sel;
    logic [MUL_W-1:0]   mul_x, mul_y;
    logic [PROD_W-1:0]  mul_p;
    logic [NUM_W-1:0]   num_mag, den_mag;

    assign num_mag = num_reg[NUM_W-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
    assign den_mag = den_reg[NUM_W-1] ? $unsigned(-den_reg) : $unsigned(den_reg);
    assign mul_sel = (state_reg == ST_ROOTSQ) ? P_MSQ : step_reg;

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (mul_sel)
            P_AD:  begin mul_x = MUL_W'(ta_reg);  mul_y = MUL_W'(td_reg);  end
            P_BC:  begin mul_x = MUL_W'(tb_reg);  mul_y = MUL_W'(tc_reg);  end
            P_AB:  begin mul_x = MUL_W'(ta_reg);  mul_y = MUL_W'(tb_reg);  end
            P_CD:  begin mul_x = MUL_W'(tc_reg);  mul_y = MUL_W'(td_reg);  end
            P_P1:  begin mul_x = MUL_W'(s_ab);    mul_y = MUL_W'(s_ac);    end
            P_P2:  begin mul_x = MUL_W'(s_bd);    mul_y = MUL_W'(s_cd);    end
            P_SAD: begin mul_x = MUL_W'(s_apd);   mul_y = MUL_W'(s_apd);   end
            P_SBC: begin mul_x = MUL_W'(s_bpc);   mul_y = MUL_W'(s_bpc);   end
            P_TT:  begin mul_x = MUL_W'(s_t);     mul_y = MUL_W'(s_t);     end
            P_DBC: begin mul_x = MUL_W'(s_bmc);   mul_y = MUL_W'(s_bmc);   end
            P_NA:  begin mul_x = MUL_W'(rows_reg); mul_y = MUL_W'(ta_reg); end
            P_NBC: begin mul_x = MUL_W'(rows_reg); mul_y = MUL_W'(s_bpc);  end
            P_NP1: begin
                mul_x = MUL_W'(rows_reg);
                mul_y = prod_reg[P_P1][MUL_W-1:0];
            end
            P_RR:  begin
                mul_x = prod_reg[P_P1][MUL_W-1:0];
                mul_y = prod_reg[P_P2][MUL_W-1:0];
            end
            P_MSQ: begin mul_x = num_mag[MUL_W-1:0]; mul_y = num_mag[MUL_W-1:0]; end
            default: ;
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // Hold products
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_MUL) || (state_reg == ST_ROOTSQ)) begin
            prod_reg[mul_sel] <= mul_p;
        end
    end

    // Signed views of tallies and products
    logic signed [NUM_W-1:0] vA, vB, vC, vD, vT, vN;
    logic signed [NUM_W-1:0] vAD, vBC, vAB, vCD, vP1, vSAD, vSBC, vTT, vDBC, vNA, vNBC;
    logic signed [NUM_W-1:0] vS, vSP;
    logic [TALLY_W+1:0]      s_max, sp_max;

    assign vA   = $signed(NUM_W'(ta_reg));
    assign vB   = $signed(NUM_W'(tb_reg));
    assign vC   = $signed(NUM_W'(tc_reg));
    assign vD   = $signed(NUM_W'(td_reg));
    assign vT   = $signed(NUM_W'(s_t));
    assign vN   = $signed(NUM_W'(rows_reg));
    assign vAD  = $signed({1'b0, prod_reg[P_AD][NUM_W-2:0]});
    assign vBC  = $signed({1'b0, prod_reg[P_BC][NUM_W-2:0]});
    assign vAB  = $signed({1'b0, prod_reg[P_AB][NUM_W-2:0]});
    assign vCD  = $signed({1'b0, prod_reg[P_CD][NUM_W-2:0]});
    assign vP1  = $signed({1'b0, prod_reg[P_P1][NUM_W-2:0]});
    assign vSAD = $signed({1'b0, prod_reg[P_SAD][NUM_W-2:0]});
    assign vSBC = $signed({1'b0, prod_reg[P_SBC][NUM_W-2:0]});
    assign vTT  = $signed({1'b0, prod_reg[P_TT][NUM_W-2:0]});
    assign vDBC = $signed({1'b0, prod_reg[P_DBC][NUM_W-2:0]});
    assign vNA  = $signed({1'b0, prod_reg[P_NA][NUM_W-2:0]});
    assign vNBC = $signed({1'b0, prod_reg[P_NBC][NUM_W-2:0]});

    // Sums of the larger cell counts for the Goodman-Kruskal family
    assign s_max = (TALLY_W+2)'((ta_reg > tb_reg) ? ta_reg : tb_reg)
                 + (TALLY_W+2)'((tc_reg > td_reg) ? tc_reg : td_reg)
                 + (TALLY_W+2)'((ta_reg > tc_reg) ? ta_reg : tc_reg)
                 + (TALLY_W+2)'((tb_reg > td_reg) ? tb_reg : td_reg);
    assign sp_max = (TALLY_W+2)'((s_ac > s_bd) ? s_ac : s_bd)
                  + (TALLY_W+2)'((s_ab > s_cd) ? s_ab : s_cd);
    assign vS  = $signed(NUM_W'(s_max));
    assign vSP = $signed(NUM_W'(sp_max));

    // Compose numerator and denominator of the selected coefficient
    logic signed [NUM_W-1:0] cmp_num, cmp_den;
    logic [DIV_DW-1:0]       cmp_root;
    mode_t                   cmp_mode;

    always_comb begin
        cmp_num  = '0;
        cmp_den  = '0;
        cmp_root = '0;
        cmp_mode = MODE_DIV;
        unique case (metric_t'(metric_reg))
            MET_JACCARD: begin cmp_num = vA; cmp_den = vA + vB + vC; end
            MET_DICE: begin cmp_num = vA <<< 1; cmp_den = (vA <<< 1) + vB + vC; end
            MET_JACCARD3W: begin
                cmp_num = vA + (vA <<< 1);
                cmp_den = vA + (vA <<< 1) + vB + vC;
            end
            MET_FAITH: begin cmp_num = (vA <<< 1) + vD; cmp_den = vT <<< 1; end
            MET_GOWER_LEG: begin
                cmp_num = (vA + vD) <<< 1;
                cmp_den = (vA <<< 1) + vB + vC + (vD <<< 1);
            end
            MET_RUSSELL_RAO: begin cmp_num = vA; cmp_den = vT; end
            MET_PEARSON_HER: begin
                cmp_num  = vAD - vBC;
                cmp_root = prod_reg[P_RR][DIV_DW-1:0];
                cmp_mode = MODE_ROOT;
            end
            MET_HAMMING: begin
                cmp_num = vB + vC;
                cmp_den = norm_reg ? vT : NUM_ONE;
            end
            MET_DENNIS: begin
                cmp_num  = vAD - vBC;
                cmp_root = prod_reg[P_NP1][DIV_DW-1:0];
                cmp_mode = MODE_ROOT;
            end
            MET_TARWID: begin cmp_num = vNA - vP1; cmp_den = vNA + vP1; end
            MET_YULEQ: begin cmp_num = vAD - vBC; cmp_den = vAD + vBC; end
            MET_YULEW: cmp_mode = MODE_YULEW;
            MET_YULEQ_DIST: begin cmp_num = vBC <<< 1; cmp_den = vAD + vBC; end
            MET_MICHAEL: begin cmp_num = (vAD - vBC) <<< 2; cmp_den = vSAD + vSBC; end
            MET_PEIRCE: begin
                cmp_num = vAB + vBC;
                cmp_den = vAB + (vBC <<< 1) + vCD;
            end
            MET_GOODMAN_KR: begin cmp_num = vS - vSP; cmp_den = (vN <<< 1) - vSP; end
            MET_ANDERBERG: begin cmp_num = vS - vSP; cmp_den = vN <<< 1; end
            MET_HAMANN: begin cmp_num = (vA + vD) - (vB + vC); cmp_den = vT; end
            MET_MEAN_MANH: begin cmp_num = vB + vC; cmp_den = vT; end
            MET_SIZED_DIFF: begin cmp_num = vSBC; cmp_den = vTT; end
            MET_SHAPE_DIFF: begin cmp_num = vNBC - vDBC; cmp_den = vTT; end
            MET_DISPERSION: begin cmp_num = vAD - vBC; cmp_den = vTT; end
            MET_FSCORE: begin
                cmp_num = vA <<< 1;
                cmp_den = (ta_reg == '0) ? '0 : (vA <<< 1) + vB + vC;
            end
            default: cmp_mode = MODE_UNDEF;
        endcase
    end

    // Iterative units
    div_req_t          div_req;
    sq_req_t           sq_req;
    logic              div_done, sq_done;
    logic [DIV_NW-1:0] div_quo;
    logic [SQ_RW-1:0]  sq_root;
    logic              div_zero;

    assign div_zero = (mode_reg != MODE_ROOT) && (den_reg == '0);

    always_comb begin
        div_req.start    = (state_reg == ST_DIV_GO) && !div_zero;
        if (mode_reg == MODE_ROOT) begin
            div_req.dividend = DIV_NW'(prod_reg[P_MSQ]) << ROOT_SHIFT;
            div_req.divisor  = root_reg;
        end else begin
            div_req.dividend = (DIV_NW'(num_mag) << FRAC_W) + DIV_NW'(den_mag >> 1);
            div_req.divisor  = DIV_DW'(den_mag);
        end
    end

    always_comb begin
        sq_req.start    = (state_reg == ST_SQX_GO) || (state_reg == ST_SQY_GO) ||
                          (state_reg == ST_SQW_GO);
        sq_req.radicand = SQ_W'(div_quo);
        if (state_reg == ST_SQX_GO) begin
            sq_req.radicand = SQ_W'(prod_reg[P_AD]) << (2 * FRAC_W);
        end else if (state_reg == ST_SQY_GO) begin
            sq_req.radicand = SQ_W'(prod_reg[P_BC]) << (2 * FRAC_W);
        end
    end

    bse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    bse_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .done    (sq_done),
        .root    (sq_root)
    );

    // Round and saturate the result
    logic [SQ_RW:0]     rnd_root;
    logic [DIV_NW-1:0]  res_mag;
    logic               res_neg, res_over, out_load;
    logic [COEF_W-1:0]  coef;

    assign rnd_root = {1'b0, sq_root} + 1'b1;
    assign res_mag  = (mode_reg == MODE_ROOT) ? DIV_NW'(rnd_root[SQ_RW:1]) : div_quo;
    assign res_neg  = (mode_reg == MODE_ROOT) ? num_reg[NUM_W-1]
                                              : (num_reg[NUM_W-1] ^ den_reg[NUM_W-1]);
    assign res_over = |res_mag[DIV_NW-1:COEF_W-1];

    always_comb begin
        if (undef_reg) begin
            coef = '0;
        end else if (res_neg) begin
            coef = res_over ? {1'b1, {(COEF_W-1){1'b0}}} : -res_mag[COEF_W-1:0];
        end else begin
            coef = res_over ? {1'b0, {(COEF_W-1){1'b1}}} : res_mag[COEF_W-1:0];
        end
    end

    assign out_load = (state_reg == ST_RESULT) && (!m_valid_reg || m_tready);

    // Sequencer and tallies
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= P_AD;
            mode_reg  <= MODE_DIV;
            undef_reg <= 1'b0;
            ta_reg    <= '0;
            tb_reg    <= '0;
            tc_reg    <= '0;
            td_reg    <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (!skip) begin
                            if (bit_first && bit_second) begin
                                ta_reg <= (ta_reg == '1) ? ta_reg : ta_reg + 1'b1;
                            end else if (bit_first) begin
                                tb_reg <= (tb_reg == '1) ? tb_reg : tb_reg + 1'b1;
                            end else if (bit_second) begin
                                tc_reg <= (tc_reg == '1) ? tc_reg : tc_reg + 1'b1;
                            end else begin
                                td_reg <= (td_reg == '1) ? td_reg : td_reg + 1'b1;
                            end
                        end
                        if (s_tlast) begin
                            state_reg <= ST_MUL;
                            step_reg  <= P_AD;
                            undef_reg <= 1'b0;
                        end
                    end
                end
                ST_MUL: begin
                    step_reg <= prod_t'(step_reg + 4'd1);
                    if (step_reg == P_RR) begin
                        state_reg <= ST_COMPOSE;
                    end
                end
                ST_COMPOSE: begin
                    num_reg  <= cmp_num;
                    den_reg  <= cmp_den;
                    root_reg <= cmp_root;
                    mode_reg <= cmp_mode;
                    unique case (cmp_mode)
                        MODE_UNDEF: begin
                            undef_reg <= 1'b1;
                            state_reg <= ST_RESULT;
                        end
                        MODE_ROOT: begin
                            if (cmp_root == '0) begin
                                undef_reg <= 1'b1;
                                state_reg <= ST_RESULT;
                            end else begin
                                state_reg <= ST_ROOTSQ;
                            end
                        end
                        MODE_YULEW: state_reg <= ST_SQX_GO;
                        default:    state_reg <= ST_DIV_GO;
                    endcase
                end
                ST_ROOTSQ: state_reg <= ST_DIV_GO;
                ST_DIV_GO: begin
                    if (div_zero) begin
                        undef_reg <= 1'b1;
                        state_reg <= ST_RESULT;
                    end else begin
                        state_reg <= ST_DIV_WAIT;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        state_reg <= (mode_reg == MODE_ROOT) ? ST_SQW_GO : ST_RESULT;
                    end
                end
                ST_SQX_GO: state_reg <= ST_SQX_WAIT;
                ST_SQX_WAIT: begin
                    if (sq_done) begin
                        xroot_reg <= sq_root;
                        state_reg <= ST_SQY_GO;
                    end
                end
                ST_SQY_GO: state_reg <= ST_SQY_WAIT;
                ST_SQY_WAIT: begin
                    if (sq_done) begin
                        num_reg   <= $signed(NUM_W'(xroot_reg)) - $signed(NUM_W'(sq_root));
                        den_reg   <= $signed(NUM_W'(xroot_reg)) + $signed(NUM_W'(sq_root));
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_SQW_GO: state_reg <= ST_SQW_WAIT;
                ST_SQW_WAIT: begin
                    if (sq_done) begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_load) begin
                        ta_reg    <= '0;
                        tb_reg    <= '0;
                        tc_reg    <= '0;
                        td_reg    <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {{(M_TDATA_W - COEF_W - 4 * TALLY_W){1'b0}},
                           td_reg, tc_reg, tb_reg, ta_reg, coef};
            m_user_reg <= undef_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

// ===== hw/rtl/bse_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; quotient holds from done until the next start.
// ----------------------------------------------------------------------------
module bse_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bse_pkg::div_req_t           req,
    output logic                        done,
    output logic [bse_pkg::DIV_NW-1:0]  quotient
);
    import bse_pkg::*;

    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              fits;

    // Trial subtract of the divisor from the shifted remainder
    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    // Count iterations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift dividend out and quotient bits in
    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/bse_isqrt.sv =====
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bse_isqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bse_pkg::sq_req_t           req,
    output logic                       done,
    output logic [bse_pkg::SQ_RW-1:0]  root
);
    import bse_pkg::*;

    logic [SQ_W-1:0]  x_reg;
    logic [SQ_RW-1:0] root_reg;
    logic [SQ_RW:0]   rem_reg;
    logic [SQ_CW-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SQ_RW+2:0] shifted;
    logic [SQ_RW+2:0] trial;
    logic [SQ_RW+2:0] diff;
    logic             fits;

    // Bring down two radicand bits and try 4r+1
    assign shifted = {rem_reg, x_reg[SQ_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign fits    = shifted >= trial;
    assign diff    = shifted - trial;

    // Count iterations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CW'(SQ_RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQ_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance remainder and partial root
    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg    <= req.radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            x_reg    <= x_reg << 2;
            rem_reg  <= fits ? diff[SQ_RW:0] : shifted[SQ_RW:0];
            root_reg <= {root_reg[SQ_RW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/bse_checker.sv =====
// ----------------------------------------------------------------------------
// Binary similarity engine port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module bse_port_props (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [bse_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic [0:0]                         m_tuser
);
    import bse_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Undefined result carries a zero coefficient
    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[COEF_W-1:0] == '0)
        else $error("undefined result with nonzero coefficient");

    // A last cell starts the computation and blocks further cells
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after last cell");

    // Input is still blocked partway through the multiplier schedule
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |-> ##8 !s_tready)
        else $error("computation ended too early");

endmodule

bind binary_similarity_engine bse_port_props u_bse_port_props (.*);
